/* src/dsfa_pkg.sv */
// Shared types and constants for the dust sensor frame assembler.
// No dependencies; used by every module of the block.
package dsfa_pkg;

	localparam int MAX_BODY_LEN  = 28;
	localparam int MIN_BODY_LEN  = 20;
	localparam int BINS_BODY_LEN = 28;
	localparam int FRAME_CAP     = MAX_BODY_LEN + 4;
	localparam int POS_W         = $clog2(FRAME_CAP + 1);
	localparam int LEFT_W        = $clog2(MAX_BODY_LEN + 1);

	localparam int NUM_READ   = 12;
	localparam int NUM_PM     = 6;
	localparam int NUM_BINS   = NUM_READ - NUM_PM;
	localparam int BODY_START = 4;
	localparam int BUF_BYTES  = 2 * NUM_READ;
	localparam int BIDX_W     = $clog2(BUF_BYTES);
	localparam int IDX_W      = 4;

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_READ - 1);

	localparam logic [7:0] PREAMBLE_A = 8'h42;
	localparam logic [7:0] PREAMBLE_B = 8'h4D;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_BAD_LEN = 2'd1;
	localparam logic [1:0] ST_BAD_SUM = 2'd2;
	localparam logic [1:0] ST_NOT_DUE = 2'd3;

	localparam logic [1:0] CFG_SAMPLE_PERIOD = 2'd0;
	localparam logic [1:0] CFG_WARMUP        = 2'd1;
	localparam logic [1:0] CFG_ENABLE        = 2'd2;

	localparam logic [15:0] RST_SAMPLE_PERIOD = 16'd300;
	localparam logic [15:0] RST_WARMUP        = 16'd30;

	typedef enum logic [2:0] {
		PH_HUNT_A = 3'd0,
		PH_HUNT_B = 3'd1,
		PH_LEN_HI = 3'd2,
		PH_LEN_LO = 3'd3,
		PH_BODY   = 3'd4
	} phase_t;

	typedef struct packed {
		logic [7:0]  rx_byte;
		logic [31:0] now_seconds;
	} in_t;

	typedef struct packed {
		logic [1:0]       status;
		logic [IDX_W-1:0] reading_index;
		logic [15:0]      reading_value;
		logic             standby_request;
		logic [31:0]      good_frames;
		logic [31:0]      bad_frames;
		logic [31:0]      sample_time;
		logic             last;
	} out_t;

	typedef struct packed {
		logic [15:0] sample_period;
		logic [15:0] warmup_interval;
		logic        enable;
	} cfg_t;

	// One frame's outcome, handed from the parser to the result sequencer
	typedef struct packed {
		logic [1:0]                   status;
		logic                         sb;
		logic [31:0]                  good;
		logic [31:0]                  bad;
		logic [31:0]                  stamp;
		logic [NUM_READ-1:0][15:0]    vals;
	} run_t;

endpackage

/* src/dsfa_parse.sv */
// Byte input register and frame parser: preamble hunt, length check,
// running checksum, due test, counters and size bins. Uses dsfa_pkg.
module dsfa_parse (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  dsfa_pkg::in_t  in_data,
	input  dsfa_pkg::cfg_t cfg,
	input  logic           emit_free,
	output logic           load_valid,
	output dsfa_pkg::run_t load
);

	logic          valid_s1;
	dsfa_pkg::in_t data_s1;

	dsfa_pkg::phase_t phase_q, phase_n;
	logic [15:0] sum_q, sum_n;
	logic [7:0]  prev_q, prev_n;
	logic [7:0]  lenhi_q, lenhi_n;
	logic        len28_q, len28_n;
	logic [dsfa_pkg::LEFT_W-1:0] left_q, left_n;
	logic [dsfa_pkg::POS_W-1:0]  wpos_q, wpos_n;
	logic [31:0] stamp_q, stamp_n;
	logic [31:0] good_q, good_n;
	logic [31:0] bad_q, bad_n;
	logic [7:0]  buf_q [dsfa_pkg::BUF_BYTES];
	logic [15:0] bins_q [dsfa_pkg::NUM_BINS];
	logic        bins_we;
	logic        buf_we;
	logic [dsfa_pkg::BIDX_W-1:0] buf_idx;

	logic        res_v;
	logic        advance;
	logic [7:0]  b;
	logic [31:0] now;
	logic [15:0] len16;
	logic [15:0] sum_acc;
	logic [dsfa_pkg::POS_W-1:0] wpos_off;
	dsfa_pkg::run_t run_c;

	assign b       = data_s1.rx_byte;
	assign now     = data_s1.now_seconds;
	assign len16   = {lenhi_q, b};
	assign sum_acc = sum_q + 16'(prev_q);
	assign wpos_off = wpos_q - dsfa_pkg::POS_W'(dsfa_pkg::BODY_START);
	assign buf_idx  = wpos_off[dsfa_pkg::BIDX_W-1:0];

	always_comb begin
		phase_n = phase_q;
		sum_n   = sum_q;
		prev_n  = prev_q;
		lenhi_n = lenhi_q;
		len28_n = len28_q;
		left_n  = left_q;
		wpos_n  = wpos_q;
		stamp_n = stamp_q;
		good_n  = good_q;
		bad_n   = bad_q;
		bins_we = 1'b0;
		buf_we  = 1'b0;
		res_v   = 1'b0;
		run_c        = '0;
		run_c.status = dsfa_pkg::ST_OK;
		if (cfg.enable) begin
			unique case (phase_q)
				dsfa_pkg::PH_HUNT_B: begin
					if (b == dsfa_pkg::PREAMBLE_B) begin
						sum_n   = sum_acc;
						prev_n  = b;
						wpos_n  = dsfa_pkg::POS_W'(2);
						phase_n = dsfa_pkg::PH_LEN_HI;
					end else begin
						phase_n = dsfa_pkg::PH_HUNT_A;
					end
				end
				dsfa_pkg::PH_LEN_HI: begin
					sum_n   = sum_acc;
					prev_n  = b;
					lenhi_n = b;
					wpos_n  = dsfa_pkg::POS_W'(3);
					phase_n = dsfa_pkg::PH_LEN_LO;
				end
				dsfa_pkg::PH_LEN_LO: begin
					sum_n  = sum_acc;
					prev_n = b;
					wpos_n = dsfa_pkg::POS_W'(dsfa_pkg::BODY_START);
					if (len16 < 16'(dsfa_pkg::MIN_BODY_LEN) ||
					    len16 > 16'(dsfa_pkg::MAX_BODY_LEN)) begin
						bad_n        = bad_q + 32'd1;
						phase_n      = dsfa_pkg::PH_HUNT_A;
						res_v        = 1'b1;
						run_c.status = dsfa_pkg::ST_BAD_LEN;
					end else begin
						left_n  = len16[dsfa_pkg::LEFT_W-1:0];
						len28_n = (len16 == 16'(dsfa_pkg::BINS_BODY_LEN));
						phase_n = dsfa_pkg::PH_BODY;
					end
				end
				dsfa_pkg::PH_BODY: begin
					if (wpos_q < dsfa_pkg::POS_W'(dsfa_pkg::FRAME_CAP)) begin
						wpos_n = wpos_q + 1'b1;
						buf_we = (wpos_q >= dsfa_pkg::POS_W'(dsfa_pkg::BODY_START)) &&
						         (wpos_off < dsfa_pkg::POS_W'(dsfa_pkg::BUF_BYTES));
					end
					sum_n  = sum_acc;
					prev_n = b;
					if (left_q != '0)
						left_n = left_q - 1'b1;
					if (left_q <= dsfa_pkg::LEFT_W'(1)) begin
						// final body byte: prev_q holds the checksum high byte
						phase_n = dsfa_pkg::PH_HUNT_A;
						res_v   = 1'b1;
						if ((now - stamp_q) < {16'd0, cfg.sample_period}) begin
							run_c.status = dsfa_pkg::ST_NOT_DUE;
						end else if (sum_q != {prev_q, b}) begin
							bad_n        = bad_q + 32'd1;
							run_c.status = dsfa_pkg::ST_BAD_SUM;
						end else begin
							stamp_n  = now;
							good_n   = good_q + 32'd1;
							bins_we  = len28_q;
							run_c.sb = (cfg.sample_period > cfg.warmup_interval);
							for (int k = 0; k < dsfa_pkg::NUM_READ; k++) begin
								if (k < dsfa_pkg::NUM_PM || len28_q)
									run_c.vals[k] = {buf_q[2*k], buf_q[2*k+1]};
								else
									run_c.vals[k] = bins_q[k - dsfa_pkg::NUM_PM];
							end
						end
					end
				end
				default: begin
					phase_n = dsfa_pkg::PH_HUNT_A;
					if (b == dsfa_pkg::PREAMBLE_A) begin
						sum_n   = 16'd0;
						prev_n  = b;
						wpos_n  = dsfa_pkg::POS_W'(1);
						phase_n = dsfa_pkg::PH_HUNT_B;
					end
				end
			endcase
		end
		run_c.good  = good_n;
		run_c.bad   = bad_n;
		run_c.stamp = stamp_n;
	end

	assign advance    = valid_s1 && (!res_v || emit_free);
	assign in_stall   = valid_s1 && !advance;
	assign load_valid = advance && res_v;
	assign load       = run_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall)
			data_s1 <= in_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= dsfa_pkg::PH_HUNT_A;
			left_q  <= '0;
			wpos_q  <= '0;
			stamp_q <= '0;
			good_q  <= '0;
			bad_q   <= '0;
			for (int j = 0; j < dsfa_pkg::NUM_BINS; j++)
				bins_q[j] <= '0;
		end else if (advance) begin
			phase_q <= phase_n;
			left_q  <= left_n;
			wpos_q  <= wpos_n;
			stamp_q <= stamp_n;
			good_q  <= good_n;
			bad_q   <= bad_n;
			if (bins_we) begin
				for (int j = 0; j < dsfa_pkg::NUM_BINS; j++)
					bins_q[j] <= {buf_q[2*(j + dsfa_pkg::NUM_PM)],
					              buf_q[2*(j + dsfa_pkg::NUM_PM) + 1]};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			sum_q   <= sum_n;
			prev_q  <= prev_n;
			lenhi_q <= lenhi_n;
			len28_q <= len28_n;
			if (buf_we)
				buf_q[buf_idx] <= b;
		end
	end

	a_body_left: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == dsfa_pkg::PH_BODY |-> left_q != '0)
		else $error("body phase with no bytes left");

	a_good_needs_ok: assert property (@(posedge clk) disable iff (!arst_n)
		advance && good_n != good_q |-> load_valid && run_c.status == dsfa_pkg::ST_OK)
		else $error("good count moved without an accepted frame");

	a_one_counter: assert property (@(posedge clk) disable iff (!arst_n)
		good_q != $past(good_q) |-> bad_q == $past(bad_q))
		else $error("good and bad counts moved together");

endmodule

/* src/dsfa_emit.sv */
// Result sequencer: holds one frame's outcome and walks its readings out;
// a frame whose status is not ST_OK gives a single entry. Uses dsfa_pkg.
module dsfa_emit (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           load_valid,
	input  dsfa_pkg::run_t load,
	output logic           emit_free,
	output logic           out_valid,
	input  logic           out_stall,
	output dsfa_pkg::out_t out_data
);

	logic                       run_valid_q;
	dsfa_pkg::run_t             run_q;
	logic [dsfa_pkg::IDX_W-1:0] idx_q;
	logic                       last_c;
	logic                       pop;

	assign last_c    = (run_q.status != dsfa_pkg::ST_OK) || (idx_q == dsfa_pkg::LAST_IDX);
	assign pop       = run_valid_q && !out_stall;
	assign emit_free = !run_valid_q || (pop && last_c);
	assign out_valid = run_valid_q;

	always_comb begin
		out_data.status          = run_q.status;
		out_data.reading_index   = idx_q;
		out_data.reading_value   = run_q.vals[idx_q];
		out_data.standby_request = run_q.sb;
		out_data.good_frames     = run_q.good;
		out_data.bad_frames      = run_q.bad;
		out_data.sample_time     = run_q.stamp;
		out_data.last            = last_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_valid_q <= 1'b0;
			idx_q       <= '0;
		end else if (load_valid) begin
			run_valid_q <= 1'b1;
			idx_q       <= '0;
		end else if (pop) begin
			if (last_c)
				run_valid_q <= 1'b0;
			else
				idx_q <= idx_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_valid)
			run_q <= load;
	end

	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		load_valid |-> emit_free)
		else $error("new request loaded over a pending run");

	a_step: assert property (@(posedge clk) disable iff (!arst_n)
		pop && !last_c && !load_valid |=> out_valid && idx_q == $past(idx_q) + 1'b1)
		else $error("reading run skipped or dropped an entry");

	a_reject_single: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && run_q.status != dsfa_pkg::ST_OK |->
		out_data.last && out_data.reading_value == 16'd0 && idx_q == '0)
		else $error("rejection result not a single zero entry");

endmodule

/* src/dust_sensor_frame_assembler_unit.sv */
// Dust sensor frame assembler, top level: configuration registers, parser
// and result sequencer. Byte results pass through the input register, then
// the result register. One byte per cycle is taken, but a byte that ends
// the next frame waits while a run is still draining; a good frame's 12
// readings leave one per cycle while result_stall is low. Reset clears control
// state, counters, stamp and size bins; there is no clearing pass.
module dust_sensor_frame_assembler_unit (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           byte_valid,
	output logic           byte_stall,
	input  dsfa_pkg::in_t  byte_data,
	output logic           result_valid,
	input  logic           result_stall,
	output dsfa_pkg::out_t result_data,
	input  logic           cfg_valid,
	output logic           cfg_ready,
	input  logic [1:0]     cfg_index,
	input  logic [15:0]    cfg_data
);

	dsfa_pkg::cfg_t cfg_q;
	logic           load_valid;
	dsfa_pkg::run_t load;
	logic           emit_free;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sample_period   <= dsfa_pkg::RST_SAMPLE_PERIOD;
			cfg_q.warmup_interval <= dsfa_pkg::RST_WARMUP;
			cfg_q.enable          <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				dsfa_pkg::CFG_SAMPLE_PERIOD: cfg_q.sample_period   <= cfg_data;
				dsfa_pkg::CFG_WARMUP:        cfg_q.warmup_interval <= cfg_data;
				dsfa_pkg::CFG_ENABLE:        cfg_q.enable          <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	dsfa_parse u_parse (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (byte_valid),
		.in_stall   (byte_stall),
		.in_data    (byte_data),
		.cfg        (cfg_q),
		.emit_free  (emit_free),
		.load_valid (load_valid),
		.load       (load)
	);

	dsfa_emit u_emit (
		.clk        (clk),
		.arst_n     (arst_n),
		.load_valid (load_valid),
		.load       (load),
		.emit_free  (emit_free),
		.out_valid  (result_valid),
		.out_stall  (result_stall),
		.out_data   (result_data)
	);

endmodule
